// File: rtl/frame_rate_meter_limiter_top_defines.svh
// Assertion macros shared by the checker.
`ifndef FRAME_RATE_METER_LIMITER_TOP_DEFINES_SVH
`define FRAME_RATE_METER_LIMITER_TOP_DEFINES_SVH

// same-cycle implication, gated by reset
`define FRML_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, gated by reset
`define FRML_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/frml_pkg.sv
`default_nettype none
package frml_pkg;
	localparam int unsigned WINDOW_DEF  = 100;
	localparam int unsigned MS_W        = 32;
	localparam int unsigned FT_W        = 16;
	localparam int unsigned FPS_W       = 25;
	localparam int unsigned BUDGET_W    = 24;
	localparam int unsigned FPS_SCALE   = 256000;
	localparam logic [BUDGET_W-1:0] BUDGET_RESET = 24'd4267;
	localparam logic [FPS_W-1:0]    FPS_MAX      = '1;
	localparam logic [FT_W-1:0]     FT_MAX       = '1;

	localparam logic OP_BEGIN = 1'b0;
	localparam logic OP_END   = 1'b1;

	typedef struct packed {
		logic start_load;
		logic end_acc;
		logic update;
		logic mul;
		logic div_step;
		logic out_load;
	} frml_cmd_t;

	typedef struct packed {
		logic div_last;
	} frml_sts_t;
endpackage
`default_nettype wire

// File: rtl/frml_ctrl.sv
`default_nettype none
module frml_ctrl
	import frml_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      in_op,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	output frml_cmd_t      cmd,
	input  wire frml_sts_t sts
);
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_MUL,
		ST_DIV,
		ST_HOLD
	} state_t;

	state_t state_q;
	logic   in_acc;
	logic   out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;

	always_comb begin
		cmd            = '0;
		cmd.start_load = in_acc && (in_op == OP_BEGIN);
		cmd.end_acc    = in_acc && (in_op == OP_END);
		cmd.update     = (state_q == ST_UPD);
		cmd.mul        = (state_q == ST_MUL);
		cmd.div_step   = (state_q == ST_DIV);
		cmd.out_load   = (state_q == ST_HOLD) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (cmd.out_load)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: if (cmd.end_acc) state_q <= ST_UPD;
				ST_UPD:  state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_DIV;
				ST_DIV:  if (sts.div_last) state_q <= ST_HOLD;
				ST_HOLD: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: rtl/frml_dp.sv
`default_nettype none
module frml_dp
	import frml_pkg::*;
#(
	parameter int unsigned WINDOW = WINDOW_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire frml_cmd_t           cmd,
	output frml_sts_t                sts,
	input  wire logic                cfg_valid,
	input  wire logic [BUDGET_W-1:0] cfg_data,
	input  wire logic [MS_W-1:0]     now_ms,
	output logic      [FPS_W-1:0]    fps_q8,
	output logic      [FT_W-1:0]     delay_ms,
	output logic      [FT_W-1:0]     frame_ms
);
	localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
	localparam int unsigned ADDR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned SUM_W  = $clog2(WINDOW * 65535 + 1);
	localparam int unsigned NUM_W  = $clog2(FPS_SCALE * WINDOW + 1);
	localparam int unsigned DC_W   = $clog2(NUM_W);
	localparam int unsigned QX_W   = (NUM_W > FPS_W) ? NUM_W : FPS_W;

	logic [BUDGET_W-1:0] budget_q;
	logic [MS_W-1:0]     start_q;
	logic [MS_W-1:0]     prev_q;
	logic                seen_q;
	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    count_q;
	logic [ADDR_W-1:0]   slot_q;
	logic [DC_W-1:0]     dcnt_q;

	logic [FT_W-1:0]     mem_q [WINDOW];
	logic [FT_W-1:0]     rd_q;
	logic [FT_W-1:0]     ft_q;
	logic [FT_W-1:0]     delay_q;
	logic [NUM_W-1:0]    num_q;
	logic [SUM_W-1:0]    rem_q;

	logic [MS_W-1:0]     since_end;
	logic [FT_W-1:0]     ft_new;
	logic [MS_W-1:0]     elapsed;
	logic [BUDGET_W:0]   slack;
	logic [FT_W-1:0]     delay_new;
	logic                full;
	logic [SUM_W:0]      trial;
	logic [SUM_W:0]      trial_sub;
	logic                ge;
	logic [QX_W-1:0]     quo_x;

	assign since_end = now_ms - prev_q;
	assign ft_new    = !seen_q ? '0 : (|since_end[MS_W-1:FT_W]) ? FT_MAX : since_end[FT_W-1:0];
	assign elapsed   = now_ms - start_q;
	assign slack     = {1'b0, budget_q} - {1'b0, elapsed[FT_W-1:0], 8'b0};
	assign delay_new = (!(|elapsed[MS_W-1:FT_W]) && !slack[BUDGET_W]) ?
		slack[BUDGET_W-1:8] : '0;
	assign full      = (count_q == CNT_W'(WINDOW));

	assign trial     = {rem_q, num_q[NUM_W-1]};
	assign trial_sub = trial - {1'b0, sum_q};
	assign ge        = (trial >= {1'b0, sum_q});
	assign quo_x     = QX_W'(num_q);

	assign sts.div_last = (dcnt_q == DC_W'(NUM_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= BUDGET_RESET;
			start_q  <= '0;
			prev_q   <= '0;
			seen_q   <= 1'b0;
			sum_q    <= '0;
			count_q  <= '0;
			slot_q   <= '0;
			dcnt_q   <= '0;
		end else begin
			if (cfg_valid)
				budget_q <= cfg_data;
			if (cmd.start_load)
				start_q <= now_ms;
			if (cmd.end_acc) begin
				prev_q <= now_ms;
				seen_q <= 1'b1;
			end
			if (cmd.update) begin
				sum_q <= sum_q - (full ? SUM_W'(rd_q) : '0) + SUM_W'(ft_q);
				if (!full)
					count_q <= count_q + 1'b1;
				slot_q <= (slot_q == ADDR_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
			end
			if (cmd.mul)
				dcnt_q <= '0;
			else if (cmd.div_step)
				dcnt_q <= dcnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.end_acc) begin
			rd_q    <= mem_q[slot_q];
			ft_q    <= ft_new;
			delay_q <= delay_new;
		end
		if (cmd.update)
			mem_q[slot_q] <= ft_q;
		if (cmd.mul) begin
			num_q <= NUM_W'(count_q * FPS_SCALE);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? trial_sub[SUM_W-1:0] : trial[SUM_W-1:0];
			num_q <= {num_q[NUM_W-2:0], ge};
		end
		if (cmd.out_load) begin
			fps_q8   <= (sum_q == '0) ? '0 :
				(quo_x > QX_W'(FPS_MAX)) ? FPS_MAX : quo_x[FPS_W-1:0];
			delay_ms <= delay_q;
			frame_ms <= ft_q;
		end
	end
endmodule
`default_nettype wire

// File: rtl/frame_rate_meter_limiter_top.sv
`default_nettype none
// Rolling-average frame rate meter and frame limiter.
// s_axis: one item per call. tuser is the op (0 begin, 1 end), tdata the
// 32-bit millisecond tick. A begin item gives no result; the block stays idle.
// An end item stores the frame time in a ring of WINDOW entries and gives one
// result on m_axis: tdata = fps_q8 [24:0], delay_ms [40:25], frame_ms [56:41],
// zero above.
// cfg: writes frame_budget_q8 (24 bits, Q8 ms); write only while idle.
// An end item occupies the block through these steps, where NUM_W is the
// quotient width of 256000*WINDOW (25 bits at WINDOW = 100): the accepting
// cycle, one ring update, one constant multiply, a restoring divider
// producing one quotient bit per cycle, and the load of the output register,
// which also raises m_axis_tvalid.
// A held result does not block intake: the next item is taken while it
// waits; only the following end item waits for the output register to clear.
// Reset (arst_n low) clears the ring state, the sum and count, the times and
// sets the budget to 4267 (about 60 fps). The ring memory itself is not
// cleared: entries are read back only once the ring has wrapped.
module frame_rate_meter_limiter_top
	import frml_pkg::*;
#(
	parameter int unsigned WINDOW = WINDOW_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_axis_tvalid,
	output logic                     s_axis_tready,
	input  wire logic [MS_W-1:0]     s_axis_tdata,  // now_ms
	input  wire logic                s_axis_tuser,  // op
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	output logic      [63:0]         m_axis_tdata,  // fps_q8, delay_ms, frame_ms, pad
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [BUDGET_W-1:0] cfg_data
);
	frml_cmd_t        cmd;
	frml_sts_t        sts;
	logic [FPS_W-1:0] fps_q8;
	logic [FT_W-1:0]  delay_ms;
	logic [FT_W-1:0]  frame_ms;

	assign cfg_ready    = 1'b1;
	assign m_axis_tdata = {7'b0, frame_ms, delay_ms, fps_q8};

	frml_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_op     (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	frml_dp #(
		.WINDOW (WINDOW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.now_ms    (s_axis_tdata),
		.fps_q8    (fps_q8),
		.delay_ms  (delay_ms),
		.frame_ms  (frame_ms)
	);
endmodule
`default_nettype wire

// File: rtl/frml_chk.sv
`default_nettype none
`include "frame_rate_meter_limiter_top_defines.svh"
module frml_chk
	import frml_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_axis_tvalid,
	input wire logic                s_axis_tready,
	input wire logic                s_axis_tuser,
	input wire logic                m_axis_tvalid,
	input wire logic                m_axis_tready,
	input wire logic [63:0]         m_axis_tdata
);
	logic end_acc;

	assign end_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_END);

	`FRML_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
	`FRML_ASSERT_NEXT(a_busy_after_end, end_acc, !s_axis_tready,
		"intake open right after an end item")
	`FRML_ASSERT_NEXT(a_no_early_result, end_acc && !m_axis_tvalid, !m_axis_tvalid,
		"result appeared one cycle after an end item")
	`FRML_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[63:57] == 7'b0,
		"nonzero padding in result")
endmodule

bind frame_rate_meter_limiter_top frml_chk u_frml_chk (.*);
`default_nettype wire

// File: test/frame_rate_meter_limiter_top_tb.sv
`default_nettype none
module frame_rate_meter_limiter_top_tb;
	import frml_pkg::*;

	localparam int unsigned WIN = WINDOW_DEF;
	localparam int unsigned LATENCY = 40;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned ITEMS_PER_PHASE = 225;

	typedef struct packed {
		logic [FPS_W-1:0] fps_q8;
		logic [FT_W-1:0]  delay_ms;
		logic [FT_W-1:0]  frame_ms;
	} frame_stats_t;

	typedef struct packed {
		logic            op;
		logic [MS_W-1:0] tick;
		logic            typed;
		frame_stats_t    want;
	} stim_row_t;

	// reset budget 4267 applies throughout this table
	localparam stim_row_t DIR_TAB [18] = '{
		'{OP_END,   32'h0000_0000, 1'b1, '{25'd0, 16'd16, 16'd0}},
		'{OP_BEGIN, 32'd100,       1'b0, '0},
		'{OP_BEGIN, 32'd110,       1'b0, '0},
		'{OP_END,   32'd126,       1'b0, '0},
		'{OP_BEGIN, 32'd200,       1'b0, '0},
		'{OP_END,   32'd200,       1'b0, '0},
		'{OP_BEGIN, 32'h0010_0000, 1'b0, '0},
		'{OP_END,   32'h0010_0005, 1'b0, '0},
		'{OP_BEGIN, 32'hFFFF_FFF8, 1'b0, '0},
		'{OP_END,   32'hFFFF_FFFA, 1'b0, '0},
		'{OP_END,   32'h0000_0004, 1'b0, '0},
		'{OP_END,   32'h0000_0004, 1'b0, '0},
		'{OP_BEGIN, 32'hFFFF_FFFF, 1'b0, '0},
		'{OP_END,   32'hFFFF_FFFF, 1'b0, '0},
		'{OP_END,   32'h0000_0000, 1'b0, '0},
		'{OP_BEGIN, 32'hAAAA_AAAA, 1'b0, '0},
		'{OP_END,   32'h5555_5555, 1'b0, '0},
		'{OP_END,   32'h5555_5565, 1'b0, '0}
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [MS_W-1:0]     s_axis_tdata = '0;  // now_ms
	logic                s_axis_tuser = OP_BEGIN;  // op
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [63:0]         m_axis_tdata;  // fps_q8, delay_ms, frame_ms, pad
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [BUDGET_W-1:0] cfg_data = '0;

	frame_rate_meter_limiter_top #(
		.WINDOW(WIN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	frame_stats_t stats_q [$];
	int unsigned errors = 0;
	int unsigned idle_cycles = 0;
	int unsigned src_idle_pct = 35;
	int unsigned dst_idle_pct = 76;
	logic [MS_W-1:0] clock_ms = '0;

	logic [BUDGET_W-1:0] m_budget = BUDGET_RESET;
	logic [MS_W-1:0]     m_start = '0;
	logic [MS_W-1:0]     m_prev_end = '0;
	bit                  m_seen = 1'b0;
	logic [FT_W-1:0]     m_ring [WIN];
	int unsigned         m_sum = 0;
	int unsigned         m_count = 0;
	int unsigned         m_slot = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic frame_stats_t predict_frame_stats(input logic [MS_W-1:0] tick);
		frame_stats_t r;
		logic [MS_W-1:0] gap;
		logic [FT_W-1:0] ft;
		logic [63:0] q;
		logic [63:0] elapsed_q8;
		logic [63:0] slack;
		gap = tick - m_prev_end;
		if (!m_seen)
			ft = '0;
		else if (gap > {16'd0, FT_MAX})
			ft = FT_MAX;
		else
			ft = gap[FT_W-1:0];
		m_seen = 1'b1;
		m_prev_end = tick;
		if (m_slot >= WIN)
			m_slot = 0;
		// full ring: oldest time leaves the sum first
		if (m_count >= WIN)
			m_sum -= m_ring[m_slot];
		else
			m_count++;
		m_ring[m_slot] = ft;
		m_sum += ft;
		m_slot = (m_slot + 1 >= WIN) ? 0 : m_slot + 1;
		if (m_sum == 0)
			q = '0;
		else
			q = (64'(FPS_SCALE) * 64'(m_count)) / 64'(m_sum);
		if (q > 64'(FPS_MAX))
			q = 64'(FPS_MAX);
		elapsed_q8 = {24'd0, tick - m_start, 8'd0};
		if (64'(m_budget) > elapsed_q8) begin
			slack = (64'(m_budget) - elapsed_q8) >> 8;
			if (slack > 64'(FT_MAX))
				slack = 64'(FT_MAX);
		end else begin
			slack = '0;
		end
		r.fps_q8 = q[FPS_W-1:0];
		r.delay_ms = slack[FT_W-1:0];
		r.frame_ms = ft;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		errors++;
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
	endtask

	task automatic send_item(input logic op, input logic [MS_W-1:0] tick, input logic typed,
			input frame_stats_t want);
		frame_stats_t pred;
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= tick;
		do @(posedge clk); while (!s_axis_tready);
		if (op == OP_END) begin
			pred = predict_frame_stats(tick);
			stats_q.push_back(typed ? want : pred);
		end else begin
			m_start = tick;
		end
	endtask

	task automatic send_frame_item(input logic op, input logic [MS_W-1:0] tick);
		send_item(op, tick, 1'b0, '0);
	endtask

	// drain, let a trailing begin item settle, then write the budget
	task automatic write_budget(input logic [BUDGET_W-1:0] val);
		s_axis_tvalid <= 1'b0;
		while (stats_q.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		m_budget = val;
	endtask

	task automatic run_random_frames(input int unsigned n);
		int unsigned sent;
		int unsigned pick;
		sent = 0;
		while (sent < n) begin
			pick = $urandom_range(99);
			if (pick < 78) begin
				send_frame_item(OP_BEGIN, clock_ms);
				clock_ms += $urandom_range(40);
				send_frame_item(OP_END, clock_ms);
				clock_ms += $urandom_range(25);
				sent += 2;
			end else if (pick < 84) begin
				clock_ms += $urandom_range(1_000_000, 65_536);
				send_frame_item(OP_END, clock_ms);
				sent++;
			end else if (pick < 89) begin
				clock_ms = $urandom;
				send_frame_item(OP_BEGIN, clock_ms);
				sent++;
			end else if (pick < 95) begin
				clock_ms += $urandom_range(40);
				send_frame_item(OP_END, clock_ms);
				sent++;
			end else begin
				send_frame_item(OP_BEGIN, $urandom);
				sent++;
			end
		end
	endtask

	always @(posedge clk) begin
		frame_stats_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (stats_q.size() == 0) begin
				report_mismatch("unexpected item", m_axis_tdata, '0);
			end else begin
				want = stats_q.pop_front();
				if (m_axis_tdata[24:0] !== want.fps_q8)
					report_mismatch("fps_q8", m_axis_tdata[24:0], want.fps_q8);
				if (m_axis_tdata[40:25] !== want.delay_ms)
					report_mismatch("delay_ms", m_axis_tdata[40:25], want.delay_ms);
				if (m_axis_tdata[56:41] !== want.frame_ms)
					report_mismatch("frame_ms", m_axis_tdata[56:41], want.frame_ms);
				if (m_axis_tdata[63:57] !== '0)
					report_mismatch("pad", m_axis_tdata[63:57], '0);
			end
		end
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
		end
	end

	initial begin
		logic [BUDGET_W-1:0] budgets [6];
		budgets[0] = 24'hFF_FFFF;
		budgets[1] = 24'd0;
		budgets[2] = BUDGET_W'($urandom_range(12800, 256));
		budgets[3] = BUDGET_RESET;
		budgets[4] = BUDGET_W'($urandom_range(24'hFF_FFFF, 0));
		budgets[5] = BUDGET_W'($urandom_range(6400, 1));
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		foreach (DIR_TAB[i])
			send_item(DIR_TAB[i].op, DIR_TAB[i].tick, DIR_TAB[i].typed, DIR_TAB[i].want);
		for (int p = 0; p < 6; p++) begin
			case (p / 2)
				0: begin
					src_idle_pct = 35;
					dst_idle_pct = 76;
				end
				1: begin
					src_idle_pct = 76;
					dst_idle_pct = 35;
				end
				default: begin
					src_idle_pct = 0;
					dst_idle_pct = 0;
				end
			endcase
			write_budget(budgets[p]);
			run_random_frames(ITEMS_PER_PHASE);
		end
		s_axis_tvalid <= 1'b0;
		while (stats_q.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire

// File: sim.f
+incdir+rtl
rtl/frml_pkg.sv
rtl/frml_ctrl.sv
rtl/frml_dp.sv
rtl/frame_rate_meter_limiter_top.sv
rtl/frml_chk.sv
test/frame_rate_meter_limiter_top_tb.sv
